/* design/b2cjk_pkg.sv */
// ----------------------------------------------------------------------------
// b2cjk_pkg
// Shared types, constants and helper functions of the byte to CJK code encoder.
// ----------------------------------------------------------------------------
package b2cjk_pkg;

  localparam int unsigned ByteW      = 8;
  localparam int unsigned CodeW      = 16;
  localparam int unsigned ValW       = 14;
  localparam int unsigned GroupBytes = 7;
  localparam int unsigned GroupW     = GroupBytes * ByteW;
  localparam int unsigned AccW       = (GroupBytes - 1) * ByteW;
  localparam int unsigned CntW       = 3;
  localparam int unsigned IdxW       = 2;
  localparam int unsigned CfgIdxW    = 1;
  localparam int unsigned QueueDepth = 2;

  localparam logic [CodeW-1:0] CodeBaseRst = 16'h4E33;
  localparam logic [CodeW-1:0] NullCodeRst = 16'h4E00;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_CODE_BASE = 1'b0,
    CFG_NULL_CODE = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic [GroupW-1:0] data;
    logic [CntW-1:0]   nbytes;
    logic [CntW-1:0]   ncodes;
    logic              full;
  } grp_t;

  // codes produced by a group of nbytes bytes
  function automatic logic [CntW-1:0] codes_for(input logic [CntW-1:0] nbytes);
    logic [CntW-1:0] n;
    case (nbytes)
      3'd1:    n = 3'd1;
      3'd2:    n = 3'd2;
      3'd3:    n = 3'd2;
      3'd4:    n = 3'd3;
      3'd5:    n = 3'd3;
      3'd6:    n = 3'd4;
      default: n = 3'd4;
    endcase
    return n;
  endfunction

  // a zero value at idx is a real zero when this is below the byte count
  function automatic logic [CntW-1:0] zero_limit(input logic [IdxW-1:0] idx);
    logic [CntW-1:0] l;
    case (idx)
      2'd0:    l = 3'd1;
      2'd1:    l = 3'd2;
      2'd2:    l = 3'd4;
      2'd3:    l = 3'd6;
      default: l = 3'd6;
    endcase
    return l;
  endfunction

endpackage

/* design/b2cjk_front.sv */
// ----------------------------------------------------------------------------
// b2cjk_front
// Packs input bytes into a group and hands complete or final groups to the
// queue.
// ----------------------------------------------------------------------------
module b2cjk_front (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [b2cjk_pkg::ByteW-1:0]       data_byte_i,
  input  logic                              is_final_i,
  input  logic                              q_full_i,
  output logic                              q_push_o,
  output b2cjk_pkg::grp_t                   q_data_o
);

  logic [b2cjk_pkg::AccW-1:0]   acc_q, acc_d;
  logic [b2cjk_pkg::CntW-1:0]   held_q, held_d;
  logic [b2cjk_pkg::CntW-1:0]   count;
  logic [b2cjk_pkg::GroupW-1:0] group;
  logic                         accept;
  logic                         full_grp;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign count      = held_q + 3'd1;
  assign full_grp   = (count == b2cjk_pkg::CntW'(b2cjk_pkg::GroupBytes));

  always_comb begin
    for (int k = 0; k < int'(b2cjk_pkg::GroupBytes); k++) begin
      if (held_q == b2cjk_pkg::CntW'(k)) begin
        group[k*b2cjk_pkg::ByteW +: b2cjk_pkg::ByteW] = data_byte_i;
      end else if (k < int'(b2cjk_pkg::GroupBytes) - 1) begin
        group[k*b2cjk_pkg::ByteW +: b2cjk_pkg::ByteW] =
          acc_q[k*b2cjk_pkg::ByteW +: b2cjk_pkg::ByteW];
      end else begin
        group[k*b2cjk_pkg::ByteW +: b2cjk_pkg::ByteW] = '0;
      end
    end
  end

  assign q_push_o        = accept && (full_grp || is_final_i);
  assign q_data_o.data   = group;
  assign q_data_o.nbytes = count;
  assign q_data_o.ncodes = b2cjk_pkg::codes_for(count);
  assign q_data_o.full   = full_grp;

  always_comb begin
    acc_d  = acc_q;
    held_d = held_q;
    if (accept) begin
      if (full_grp || is_final_i) begin
        acc_d  = '0;
        held_d = '0;
      end else begin
        acc_d  = group[b2cjk_pkg::AccW-1:0];
        held_d = count;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q  <= '0;
      held_q <= '0;
    end else begin
      acc_q  <= acc_d;
      held_q <= held_d;
    end
  end

endmodule

/* design/b2cjk_queue.sv */
// ----------------------------------------------------------------------------
// b2cjk_queue
// Small FIFO of packed groups between the front and the back.
// ----------------------------------------------------------------------------
module b2cjk_queue #(
  parameter int unsigned Depth = b2cjk_pkg::QueueDepth
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  b2cjk_pkg::grp_t data_i,
  output logic            full_o,
  input  logic            pop_i,
  output b2cjk_pkg::grp_t data_o,
  output logic            empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  b2cjk_pkg::grp_t mem_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

/* design/b2cjk_back.sv */
// ----------------------------------------------------------------------------
// b2cjk_back
// Takes groups from the queue and emits one code per cycle into the output
// register unless the output stalls. Holds the configuration registers.
// ----------------------------------------------------------------------------
module b2cjk_back (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [b2cjk_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [b2cjk_pkg::CodeW-1:0]        cfg_data_i,
  input  logic                               q_empty_i,
  input  b2cjk_pkg::grp_t                    q_data_i,
  output logic                               q_pop_o,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [b2cjk_pkg::CodeW-1:0]        code_o,
  output logic                               end_of_run_o
);

  logic [b2cjk_pkg::CodeW-1:0] base_q, null_q;
  b2cjk_pkg::grp_t             ent_q, ent_d;
  logic                        busy_q, busy_d;
  logic [b2cjk_pkg::IdxW-1:0]  idx_q, idx_d;
  logic                        oval_q, oval_d;
  logic [b2cjk_pkg::CodeW-1:0] code_q, code_d;
  logic                        end_q, end_d;
  logic                        advance, last, load;
  logic [b2cjk_pkg::ValW-1:0]  val;

  assign advance = busy_q && (!oval_q || !out_stall_i);
  assign last    = ({1'b0, idx_q} + 3'd1) == ent_q.ncodes;
  assign load    = !q_empty_i && (!busy_q || (advance && last));
  assign q_pop_o = load;

  always_comb begin
    case (idx_q)
      2'd0:    val = ent_q.data[0*b2cjk_pkg::ValW +: b2cjk_pkg::ValW];
      2'd1:    val = ent_q.data[1*b2cjk_pkg::ValW +: b2cjk_pkg::ValW];
      2'd2:    val = ent_q.data[2*b2cjk_pkg::ValW +: b2cjk_pkg::ValW];
      2'd3:    val = ent_q.data[3*b2cjk_pkg::ValW +: b2cjk_pkg::ValW];
      default: val = '0;
    endcase
  end

  always_comb begin
    ent_d  = ent_q;
    busy_d = busy_q;
    idx_d  = idx_q;
    if (load) begin
      ent_d  = q_data_i;
      busy_d = 1'b1;
      idx_d  = '0;
    end else if (advance) begin
      if (last) begin
        busy_d = 1'b0;
      end else begin
        idx_d = idx_q + b2cjk_pkg::IdxW'(1);
      end
    end
  end

  always_comb begin
    oval_d = oval_q;
    code_d = code_q;
    end_d  = end_q;
    if (advance) begin
      oval_d = 1'b1;
      end_d  = last;
      if (val != '0 || ent_q.full || b2cjk_pkg::zero_limit(idx_q) < ent_q.nbytes) begin
        code_d = base_q + {2'b00, val};
      end else begin
        code_d = null_q;
      end
    end else if (!out_stall_i) begin
      oval_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= b2cjk_pkg::CodeBaseRst;
      null_q <= b2cjk_pkg::NullCodeRst;
    end else if (cfg_we_i) begin
      case (b2cjk_pkg::cfg_idx_e'(cfg_idx_i))
        b2cjk_pkg::CFG_CODE_BASE: base_q <= cfg_data_i;
        b2cjk_pkg::CFG_NULL_CODE: null_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
      oval_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      idx_q  <= idx_d;
      oval_q <= oval_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q  <= ent_d;
    code_q <= code_d;
    end_q  <= end_d;
  end

  assign out_valid_o  = oval_q;
  assign code_o       = code_q;
  assign end_of_run_o = end_q;

endmodule

/* design/bytes_to_cjk_code_encoder.sv */
// ----------------------------------------------------------------------------
// bytes_to_cjk_code_encoder
// Base16384-style encoder: bytes in, 16-bit character codes out.
// ----------------------------------------------------------------------------
// Input channel: one byte per word with is_final marking the last byte of a
// stream. Output channel: one code per word, end_of_run set on the last code
// caused by an input byte. Both use valid/stall.
// Seven bytes form a group that yields four codes; a final byte closing a
// partial group of 1..6 bytes yields 1..4 codes. Other bytes yield nothing.
// Bytes are taken at one per cycle while the group queue has room. The back
// end emits one code per cycle, so seven bytes (four codes) sustain the full
// input rate. A closed group passes the queue and the back end's group
// register before its first code is registered in the output register.
// A stall on the output holds the output register; the back end stops, the
// queue fills and then the input stalls.
// Reset clears the partial group, the queue and the output valid flag and
// loads code_base = 0x4E33, null_code = 0x4E00. cfg_idx 0 writes code_base,
// 1 writes null_code; write only while the block is idle.
// ----------------------------------------------------------------------------
module bytes_to_cjk_code_encoder #(
  parameter int unsigned QueueDepth = b2cjk_pkg::QueueDepth
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [b2cjk_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [b2cjk_pkg::CodeW-1:0]        cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [b2cjk_pkg::ByteW-1:0]        data_byte_i,
  input  logic                               is_final_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [b2cjk_pkg::CodeW-1:0]        code_o,
  output logic                               end_of_run_o
);

  b2cjk_pkg::grp_t push_data, pop_data;
  logic            push, pop, q_full, q_empty;

  b2cjk_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .data_byte_i (data_byte_i),
    .is_final_i  (is_final_i),
    .q_full_i    (q_full),
    .q_push_o    (push),
    .q_data_o    (push_data)
  );

  b2cjk_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_data),
    .full_o  (q_full),
    .pop_i   (pop),
    .data_o  (pop_data),
    .empty_o (q_empty)
  );

  b2cjk_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .q_empty_i    (q_empty),
    .q_data_i     (pop_data),
    .q_pop_o      (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .code_o       (code_o),
    .end_of_run_o (end_of_run_o)
  );

endmodule

/* design/b2cjk_checker.sv */
// ----------------------------------------------------------------------------
// b2cjk_checker
// Port-level checks of the encoder, bound to the top level.
// ----------------------------------------------------------------------------
module b2cjk_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input logic [b2cjk_pkg::CodeW-1:0] code_o,
  input logic                        end_of_run_o
);

  logic       out_acc;
  logic [2:0] run_q;

  assign out_acc = out_valid_o && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= '0;
    end else if (out_acc) begin
      run_q <= end_of_run_o ? 3'd0 : run_q + 3'd1;
    end
  end

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(code_o) && $stable(end_of_run_o))
    else $error("output word changed while stalled");

  a_run_cont: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && !end_of_run_o |=> out_valid_o)
    else $error("gap inside a run of codes");

  a_run_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc |-> run_q <= 3'd3)
    else $error("run longer than four codes");

endmodule

bind bytes_to_cjk_code_encoder b2cjk_checker u_b2cjk_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .code_o       (code_o),
  .end_of_run_o (end_of_run_o)
);
